FILE: rtl/core/stream_match_insert_unit_assert.svh
// ----------------------------------------------------------------------------
// stream_match_insert_unit_assert.svh
// assertion macros used by the stream match-insert checker
// ----------------------------------------------------------------------------
`ifndef STREAM_MATCH_INSERT_UNIT_ASSERT_SVH
`define STREAM_MATCH_INSERT_UNIT_ASSERT_SVH

// same-cycle implication, switched off while reset is held
`define SMI_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("smi assertion failed");

// next-cycle implication, switched off while reset is held
`define SMI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("smi assertion failed");

// next-cycle implication that also holds across reset
`define SMI_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("smi assertion failed");

`endif

FILE: rtl/core/smi_pkg.sv
// ----------------------------------------------------------------------------
// smi_pkg
// types and constants shared by the stream match-insert blocks
// ----------------------------------------------------------------------------
package smi_pkg;

    // pattern and insertion registers hold this many bytes
    localparam int REG_BYTES  = 16;
    localparam int BYTE_IDX_W = 4;
    localparam int LEN_W      = 5;
    localparam int WORD_W     = 64;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HI  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INS_LEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INS_LO  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INS_HI  = 3'd5;

    // decoupling queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef logic [7:0] t_byte;
    typedef logic [REG_BYTES-1:0][7:0] t_byte_vec;

    // pattern as seen by the front, length already clipped
    typedef struct packed {
        logic [LEN_W-1:0] len;
        t_byte_vec        bytes;
    } t_pat_cfg;

    // insertion string as seen by the back, length already clipped
    typedef struct packed {
        logic [LEN_W-1:0] len;
        t_byte_vec        bytes;
    } t_ins_cfg;

    // one classified input byte
    typedef struct packed {
        t_byte data;
        logic  hit;
    } t_item;

endpackage

FILE: rtl/core/smi_front.sv
// ----------------------------------------------------------------------------
// smi_front
// takes input bytes, keeps the match window and flags completed matches
// ----------------------------------------------------------------------------
module smi_front #(
    parameter int PATTERN_MAX = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic            i_q_full,
    input  logic [7:0]      i_in_byte,
    input  smi_pkg::t_pat_cfg i_cfg,
    output logic            o_full,
    output logic            o_wr,
    output smi_pkg::t_item  o_item
);
    import smi_pkg::*;

    localparam int PLIM = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;
    localparam int CNTW = $clog2(PATTERN_MAX + 1);
    localparam int CMPW = (CNTW > LEN_W) ? CNTW : LEN_W;

    t_byte           r_win [PLIM];
    t_byte           win_next [PLIM];
    logic [CNTW-1:0] r_cnt;
    logic [CNTW-1:0] n_cnt;
    logic [CNTW-1:0] cnt_next;
    logic [PLIM-1:0] hit_len;
    logic [PLIM-1:0] len_hot;
    logic            cnt_ok;
    logic            hit;
    logic            accept;

    assign accept = i_push && !i_q_full;
    assign o_full = i_q_full;

    // window as it stands once this byte is in, newest first
    always_comb begin
        win_next[0] = i_in_byte;
        for (int k = 1; k < PLIM; k++) begin
            win_next[k] = r_win[k-1];
        end
    end

    // one comparator row per candidate pattern length
    for (genvar gl = 1; gl <= PLIM; gl++) begin : g_len
        always_comb begin
            hit_len[gl-1] = 1'b1;
            for (int i = 0; i < gl; i++) begin
                if (win_next[gl-1-i] != i_cfg.bytes[i]) begin
                    hit_len[gl-1] = 1'b0;
                end
            end
            len_hot[gl-1] = (i_cfg.len == LEN_W'(gl));
        end
    end

    assign cnt_next = (r_cnt == CNTW'(PATTERN_MAX)) ? r_cnt : r_cnt + CNTW'(1);
    assign cnt_ok   = CMPW'(cnt_next) >= CMPW'(i_cfg.len);
    assign hit      = cnt_ok && |(hit_len & len_hot);
    assign n_cnt    = hit ? '0 : cnt_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= win_next;
        end
    end

    assign o_wr        = accept;
    assign o_item.data = i_in_byte;
    assign o_item.hit  = hit;

endmodule

FILE: rtl/core/smi_queue.sv
// ----------------------------------------------------------------------------
// smi_queue
// short register queue of classified bytes between front and back
// ----------------------------------------------------------------------------
module smi_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  smi_pkg::t_item i_wr_item,
    input  logic           i_rd,
    output smi_pkg::t_item o_rd_item,
    output logic           o_full,
    output logic           o_empty
);
    import smi_pkg::*;

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    assign o_full    = (r_count == QCNT_W'(QDEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_item = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_wr && !i_rd) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_wr && i_rd) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

endmodule

FILE: rtl/core/smi_back.sv
// ----------------------------------------------------------------------------
// smi_back
// expands each classified byte into its echo and insertion beats
// ----------------------------------------------------------------------------
module smi_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  smi_pkg::t_ins_cfg i_cfg,
    input  logic              i_q_empty,
    input  smi_pkg::t_item    i_q_item,
    output logic              o_q_rd,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [7:0]        o_out_byte,
    output logic              o_is_inserted,
    output logic              o_last
);
    import smi_pkg::*;

    logic                  r_in_ins;
    logic [BYTE_IDX_W-1:0] r_ins_cnt;
    logic [BYTE_IDX_W-1:0] n_ins_cnt;
    logic                  r_out_valid;
    t_byte                 r_out_byte;
    logic                  r_out_ins;
    logic                  r_out_last;
    t_byte                 beat_byte;
    logic                  beat_last;
    logic                  adv;
    logic                  go;

    assign adv = !r_out_valid || i_pop;
    assign go  = adv && !i_q_empty;

    always_comb begin
        if (r_in_ins) begin
            beat_byte = i_cfg.bytes[r_ins_cnt];
            beat_last = ({1'b0, r_ins_cnt} == LEN_W'(i_cfg.len - LEN_W'(1)));
        end else begin
            beat_byte = i_q_item.data;
            beat_last = !(i_q_item.hit && (i_cfg.len != '0));
        end
        if (beat_last || !r_in_ins) begin
            n_ins_cnt = '0;
        end else begin
            n_ins_cnt = r_ins_cnt + BYTE_IDX_W'(1);
        end
    end

    assign o_q_rd = go && beat_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ins    <= 1'b0;
            r_ins_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= !i_q_empty;
            end
            if (go) begin
                r_in_ins  <= !beat_last;
                r_ins_cnt <= n_ins_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out_byte <= beat_byte;
            r_out_ins  <= r_in_ins;
            r_out_last <= beat_last;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_is_inserted = r_out_ins;
    assign o_last        = r_out_last;

endmodule

FILE: rtl/core/stream_match_insert_unit.sv
// ----------------------------------------------------------------------------
// stream_match_insert_unit
// byte stream matcher that inserts a string after each completed pattern
// ----------------------------------------------------------------------------
// echo path: an accepted byte goes into the queue, then the output register
// throughput: one input byte per cycle while full is low; a match adds one
//   output beat per inserted byte, all through the back end's single output register
// reset: synchronous, active low; clears the match count, queue and output,
//   and loads register defaults (pattern length 1, all else zero)
// ----------------------------------------------------------------------------
module stream_match_insert_unit #(
    parameter int PATTERN_MAX = 16,
    parameter int INSERT_MAX  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input byte queue side
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     i_in_byte,
    // result queue side
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     o_out_byte,
    output logic                           o_is_inserted,
    output logic                           o_last,
    // register write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [smi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [smi_pkg::WORD_W-1:0]     i_cfg_data
);
    import smi_pkg::*;

    // effective length caps
    localparam int PLIM = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;
    localparam int ILIM = (INSERT_MAX < REG_BYTES) ? INSERT_MAX : REG_BYTES;

    // configuration registers
    logic [LEN_W-1:0]  r_pat_len;
    logic [WORD_W-1:0] r_pat_lo;
    logic [WORD_W-1:0] r_pat_hi;
    logic [LEN_W-1:0]  r_ins_len;
    logic [WORD_W-1:0] r_ins_lo;
    logic [WORD_W-1:0] r_ins_hi;

    t_pat_cfg pat_cfg;
    t_ins_cfg ins_cfg;

    // front to queue, queue to back
    logic  q_wr;
    t_item q_wr_item;
    logic  q_rd;
    t_item q_rd_item;
    logic  q_full;
    logic  q_empty;

    // register writes are always taken; software must write only while idle, which the block does not enforce
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len <= LEN_W'(1);
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_ins_len <= '0;
            r_ins_lo  <= '0;
            r_ins_hi  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PAT_LEN: begin
                    r_pat_len <= i_cfg_data[LEN_W-1:0];
                end
                REG_PAT_LO: begin
                    r_pat_lo <= i_cfg_data;
                end
                REG_PAT_HI: begin
                    r_pat_hi <= i_cfg_data;
                end
                REG_INS_LEN: begin
                    r_ins_len <= i_cfg_data[LEN_W-1:0];
                end
                REG_INS_LO: begin
                    r_ins_lo <= i_cfg_data;
                end
                REG_INS_HI: begin
                    r_ins_hi <= i_cfg_data;
                end
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    // clip lengths to what the hardware holds; byte k sits at bits 8k upward
    always_comb begin
        pat_cfg.len   = (r_pat_len > LEN_W'(PLIM)) ? LEN_W'(PLIM) : r_pat_len;
        pat_cfg.bytes = {r_pat_hi, r_pat_lo};
        ins_cfg.len   = (r_ins_len > LEN_W'(ILIM)) ? LEN_W'(ILIM) : r_ins_len;
        ins_cfg.bytes = {r_ins_hi, r_ins_lo};
    end

    // front: window, count since last match, match decision
    smi_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_q_full  (q_full),
        .i_in_byte (i_in_byte),
        .i_cfg     (pat_cfg),
        .o_full    (full),
        .o_wr      (q_wr),
        .o_item    (q_wr_item)
    );

    // decoupling queue so a long insertion does not stall the front at once
    smi_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_item (q_wr_item),
        .i_rd      (q_rd),
        .o_rd_item (q_rd_item),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    // back: echo beat, then insertion beats, into the output register
    smi_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (ins_cfg),
        .i_q_empty     (q_empty),
        .i_q_item      (q_rd_item),
        .o_q_rd        (q_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_byte    (o_out_byte),
        .o_is_inserted (o_is_inserted),
        .o_last        (o_last)
    );

endmodule

FILE: rtl/core/smi_checker.sv
// ----------------------------------------------------------------------------
// smi_checker
// port-level checks on the stream match-insert result stream
// ----------------------------------------------------------------------------
`include "stream_match_insert_unit_assert.svh"

module smi_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_pop,
    input logic       i_empty,
    input logic       i_full,
    input logic [7:0] i_out_byte,
    input logic       i_is_inserted,
    input logic       i_last
);

    // high between a popped beat without last and the end of that item
    logic r_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid <= 1'b0;
        end else if (i_pop && !i_empty) begin
            r_mid <= !i_last;
        end
    end

    `SMI_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, i_empty && !i_full)
    `SMI_ASSERT_NEXT(a_held_beat, i_clk, i_rst_n, !i_empty && !i_pop, !i_empty && $stable(i_out_byte) && $stable(i_is_inserted) && $stable(i_last))
    `SMI_ASSERT_IMPLY(a_tail_inserted, i_clk, i_rst_n, !i_empty && r_mid, i_is_inserted)
    `SMI_ASSERT_IMPLY(a_head_echoed, i_clk, i_rst_n, !i_empty && !r_mid, !i_is_inserted)

endmodule

bind stream_match_insert_unit smi_checker u_smi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_pop         (pop),
    .i_empty       (empty),
    .i_full        (full),
    .i_out_byte    (o_out_byte),
    .i_is_inserted (o_is_inserted),
    .i_last        (o_last)
);

FILE: tb/smi_tb_pkg.sv
// ----------------------------------------------------------------------------
// smi_tb_pkg
// scoreboard for the stream match-insert unit: predicts the output text
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smi_tb_pkg;

    import smi_pkg::*;

    localparam int PATTERN_MAX = 16;
    localparam int INSERT_MAX  = 16;
    localparam int PAT_CAP = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;
    localparam int INS_CAP = (INSERT_MAX < REG_BYTES) ? INSERT_MAX : REG_BYTES;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE0 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE1 = 3'd7;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       inserted;
        logic       final_beat;
    } t_text_beat;

    class smi_scoreboard;

        logic [LEN_W-1:0]  pat_len_reg;
        logic [WORD_W-1:0] pat_lo_reg;
        logic [WORD_W-1:0] pat_hi_reg;
        logic [LEN_W-1:0]  ins_len_reg;
        logic [WORD_W-1:0] ins_lo_reg;
        logic [WORD_W-1:0] ins_hi_reg;

        logic [7:0]  window [PATTERN_MAX];
        int unsigned since_match;

        t_text_beat  text_due [$];
        int unsigned beats_seen;
        int unsigned fail_count;

        function new();
            pat_len_reg = 5'd1;
            pat_lo_reg  = '0;
            pat_hi_reg  = '0;
            ins_len_reg = '0;
            ins_lo_reg  = '0;
            ins_hi_reg  = '0;
            foreach (window[i]) window[i] = 8'h00;
            since_match = 0;
            beats_seen  = 0;
            fail_count  = 0;
        endfunction

        function void reg_write(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
            case (idx)
                REG_PAT_LEN: pat_len_reg = data[LEN_W-1:0];
                REG_PAT_LO:  pat_lo_reg  = data;
                REG_PAT_HI:  pat_hi_reg  = data;
                REG_INS_LEN: ins_len_reg = data[LEN_W-1:0];
                REG_INS_LO:  ins_lo_reg  = data;
                REG_INS_HI:  ins_hi_reg  = data;
                default: ;
            endcase
        endfunction

        // one accepted text byte: echo, then the insertion string on a match
        function void scan_byte(logic [7:0] b);
            int unsigned plen;
            int unsigned ilen;
            logic [8*REG_BYTES-1:0] pat;
            logic [8*REG_BYTES-1:0] ins;
            bit hit;
            plen = (pat_len_reg > PAT_CAP) ? PAT_CAP : pat_len_reg;
            ilen = (ins_len_reg > INS_CAP) ? INS_CAP : ins_len_reg;
            pat  = {pat_hi_reg, pat_lo_reg};
            ins  = {ins_hi_reg, ins_lo_reg};
            for (int i = PATTERN_MAX - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = b;
            if (since_match < PATTERN_MAX) since_match++;
            hit = (plen > 0) && (since_match >= plen);
            for (int i = 0; i < plen; i++)
                if (window[plen-1-i] != pat[8*i +: 8]) hit = 1'b0;
            text_due.push_back('{b, 1'b0, !(hit && ilen > 0)});
            if (hit) begin
                since_match = 0;
                for (int i = 0; i < ilen; i++)
                    text_due.push_back('{ins[8*i +: 8], 1'b1, (i == ilen - 1)});
            end
        endfunction

        task report_mismatch(string msg);
            fail_count++;
            $display("mismatch: %s", msg);
        endtask

        task check_beat(logic [7:0] got_byte, logic got_ins, logic got_last);
            t_text_beat want;
            beats_seen++;
            if (text_due.size() == 0) begin
                report_mismatch($sformatf("beat %0d: byte %02h with nothing due",
                                          beats_seen, got_byte));
            end else begin
                want = text_due.pop_front();
                if (got_byte !== want.text_byte || got_ins !== want.inserted ||
                    got_last !== want.final_beat)
                    report_mismatch($sformatf(
                        "beat %0d: got %02h ins %0b last %0b, want %02h ins %0b last %0b",
                        beats_seen, got_byte, got_ins, got_last,
                        want.text_byte, want.inserted, want.final_beat));
            end
        endtask

        function int pending();
            return text_due.size();
        endfunction

        task check_leftover();
            if (text_due.size() != 0)
                report_mismatch($sformatf("%0d beats never arrived", text_due.size()));
        endtask

    endclass

endpackage

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the stream match-insert unit
// ----------------------------------------------------------------------------
// text bytes go in through the push/full side, output beats are popped and
// compared beat by beat against the scoreboard's predicted text; a short
// directed part covers reset settings, non-overlapping matches, saturated
// lengths and unused register indexes, then random phases reprogram the
// registers while idle and feed text built mostly from the pattern itself
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import smi_pkg::*;
    import smi_tb_pkg::*;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push    = 1'b0;
    logic                 full;
    logic [7:0]           i_in_byte = 8'h00;
    logic                 empty;
    logic                 pop     = 1'b0;
    logic [7:0]           o_out_byte;
    logic                 o_is_inserted;
    logic                 o_last;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_PAT_LEN;
    logic [WORD_W-1:0]    i_cfg_data  = '0;

    smi_scoreboard sb;

    // idle control for each side; quiet means back-to-back beats
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;

    // pattern as the text generator sees it, length already clipped
    int unsigned            gen_plen = 1;
    logic [8*REG_BYTES-1:0] gen_pat  = '0;

    stream_match_insert_unit #(
        .PATTERN_MAX (PATTERN_MAX),
        .INSERT_MAX  (INSERT_MAX)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_in_byte     (i_in_byte),
        .empty         (empty),
        .pop           (pop),
        .o_out_byte    (o_out_byte),
        .o_is_inserted (o_is_inserted),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #2ms;
        $display("[stream_match_insert_unit] ERROR");
        $finish;
    end

    // mostly no gap, sometimes a short one, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result side: pop toggled at the falling edge, one decision per cycle
    initial begin : rx_side
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else begin
                pop <= 1'b1;
                if (!rx_quiet) stall = pick_gap();
            end
        end
    end

    // every popped beat is checked at the edge that takes it
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.check_beat(o_out_byte, o_is_inserted, o_last);
    end

    // one text byte; push stays high across back-to-back beats
    task automatic push_byte(logic [7:0] b);
        int gap;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push      <= 1'b1;
        i_in_byte <= b;
        forever begin
            @(posedge i_clk);
            if (!full) break;
        end
        sb.scan_byte(b);
    endtask

    task automatic tx_stop();
        @(negedge i_clk);
        push <= 1'b0;
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        sb.reg_write(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // block idle: nothing due, then a settling wait for the pipeline to empty
    task automatic settle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // full register load, sometimes followed by a write to an unused index
    task automatic load_regs(logic [LEN_W-1:0] plen, logic [8*REG_BYTES-1:0] pat,
                             logic [LEN_W-1:0] ilen, logic [8*REG_BYTES-1:0] ins);
        cfg_write(REG_PAT_LEN, {$urandom, $urandom} & ~64'h1F | plen);
        cfg_write(REG_PAT_LO,  pat[63:0]);
        cfg_write(REG_PAT_HI,  pat[127:64]);
        cfg_write(REG_INS_LEN, {$urandom, $urandom} & ~64'h1F | ilen);
        cfg_write(REG_INS_LO,  ins[63:0]);
        cfg_write(REG_INS_HI,  ins[127:64]);
        if ($urandom_range(0, 1))
            cfg_write($urandom_range(0, 1) ? REG_SPARE0 : REG_SPARE1, {$urandom, $urandom});
        gen_plen = (plen > PAT_CAP) ? PAT_CAP : plen;
        gen_pat  = pat;
    endtask

    // text that is mostly whole patterns, some spoilt, mixed with noise
    task automatic send_text(int n_items);
        int sent;
        int spoil;
        logic [7:0] b;
        sent = 0;
        while (sent < n_items) begin
            if (gen_plen > 0 && $urandom_range(0, 9) < 6) begin
                spoil = ($urandom_range(0, 9) == 0) ? $urandom_range(0, gen_plen - 1) : -1;
                for (int k = 0; k < gen_plen; k++) begin
                    b = gen_pat[8*k +: 8];
                    if (k == spoil) b = b ^ (8'h01 << $urandom_range(0, 7));
                    push_byte(b);
                    sent++;
                end
            end else begin
                b = $urandom_range(0, 1) ? 8'($urandom) : gen_pat[8*$urandom_range(0, 15) +: 8];
                push_byte(b);
                sent++;
            end
        end
        tx_stop();
    endtask

    function automatic logic [8*REG_BYTES-1:0] rand_bytes();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    initial begin : main
        logic [LEN_W-1:0] plen;
        logic [LEN_W-1:0] ilen;
        sb = new();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: one-byte pattern of zero, empty insertion string,
        // so a zero byte matches but only its echo comes out
        gen_plen = 1;
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h80);
        tx_stop();
        settle();

        // two-byte pattern on a run of the same byte: matches may not overlap
        load_regs(5'd2, 128'h6161, 5'd3, 128'h5A5958);
        cfg_write(REG_SPARE0, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(REG_SPARE1, 64'h0000_0000_0000_001F);
        repeat (5) push_byte(8'h61);
        tx_stop();
        settle();

        // lengths past the register size saturate at the full sixteen bytes
        load_regs(5'd31, 128'hFF01_8040_2010_0804_7FFE_00FF_AA55_00FF,
                  5'd31, 128'h0011_2233_4455_6677_8899_AABB_CCDD_EEFF);
        for (int k = 0; k < REG_BYTES; k++) push_byte(gen_pat[8*k +: 8]);
        tx_stop();

        // random phases: registers reloaded while idle, extremes in rotation
        for (int p = 0; p < 10; p++) begin
            settle();
            case (p % 5)
                0:       plen = 5'd1;
                1:       plen = 5'd16;
                2:       plen = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
                default: plen = 5'($urandom_range(1, 4));
            endcase
            case (p % 4)
                0:       ilen = 5'd0;
                1:       ilen = 5'd16;
                2:       ilen = 5'($urandom_range(17, 31));
                default: ilen = 5'($urandom_range(1, 5));
            endcase
            load_regs(plen, rand_bytes(), ilen, rand_bytes());
            tx_quiet = (p % 3 == 2);
            rx_quiet = (p % 3 == 2);
            send_text(17);
        end

        // drain, then let the pipeline run dry before the verdict
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        sb.check_leftover();
        if (sb.fail_count == 0)
            $display("[stream_match_insert_unit] OK");
        else
            $display("[stream_match_insert_unit] ERROR");
        $finish;
    end

endmodule
